// ----- design/prle_pkg.sv -----
// Package for the PCX run-length encoder: run and command types, constants
// and the count-byte helpers used by the back end.
// No dependencies.
package prle_pkg;

  // Longest run before a forced flush
  localparam int MaxRun = 63;
  localparam int RunLenW = 6;
  // Count-byte tag; values at or above it need an explicit count
  localparam logic [7:0] CountTag = 8'hC0;
  // Depth of the command queue between front and back end
  localparam int FifoDepth = 4;
  localparam int FifoPtrW = $clog2(FifoDepth);

  // One closed run
  typedef struct packed {
    logic [7:0]         value;
    logic [RunLenW-1:0] length;
  } run_t;

  // Runs closed by one pixel: the previous run, then the new one
  typedef struct packed {
    logic a_vld;
    run_t a;
    logic b_vld;
    run_t b;
  } cmd_t;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // A run needs a count byte unless it is a single byte below the tag
  function automatic logic needs_count(run_t r);
    needs_count = (r.length > RunLenW'(1)) || (r.value >= CountTag);
  endfunction

  function automatic logic [7:0] count_byte(run_t r);
    count_byte = CountTag | {{(8 - RunLenW){1'b0}}, r.length};
  endfunction

endpackage

// ----- design/pcx_run_length_encoder_top.sv -----
// PCX run-length encoder, top level: front end, command queue and back end.
// Depends on prle_pkg, prle_front, prle_fifo and prle_back.
//
// Usage:
//   Slave stream: one pixel per word in tdata[7:0]; tlast marks the last
//   pixel of an image row. Master stream: one encoded byte per word in
//   tdata[7:0]; tlast marks the last byte caused by one input pixel.
//   Runs end on a pixel change, at a length of 63 or at row end, and are
//   sent as the value alone (single pixel below 0xC0) or as 0xC0|length
//   followed by the value. A pixel causes zero to four output bytes.
//   The first byte of a pixel passes the command queue, then the output
//   register. Throughput: one pixel per cycle while the queue is not full;
//   output runs at one byte per cycle while the receiver is ready, set by the
//   single output register, and a four-entry command queue absorbs the bursts.
//   When the receiver stalls, the output word holds and the queue fills;
//   s_axis_tready_o drops only once the queue is full.
//   Reset clears the open run, empties the queue and drops tvalid.
module pcx_run_length_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Pixel input
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] pixel
  input  logic       s_axis_tlast_i,   // row_end
  // Encoded output
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // out_last
);
  import prle_pkg::*;

  cmd_t       push_cmd, head_cmd;
  logic       push, pop;
  fifo_stat_t stat;

  prle_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_vld_i (s_axis_tvalid_i),
    .pixel_i   (s_axis_tdata_i),
    .row_end_i (s_axis_tlast_i),
    .pix_rdy_o (s_axis_tready_o),
    .stat_i    (stat),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  prle_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (stat)
  );

  prle_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_cmd),
    .stat_i     (stat),
    .pop_o      (pop),
    .out_vld_o  (m_axis_tvalid_o),
    .out_rdy_i  (m_axis_tready_i),
    .out_byte_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

endmodule

// ----- design/prle_front.sv -----
// Front end of the PCX run-length encoder: keeps the open run and turns each
// pixel into a command of up to two closed runs. Depends on prle_pkg.
module prle_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_vld_i,
  input  logic [7:0]        pixel_i,
  input  logic              row_end_i,
  output logic              pix_rdy_o,
  input  prle_pkg::fifo_stat_t stat_i,
  output logic              push_o,
  output prle_pkg::cmd_t    cmd_o
);
  import prle_pkg::*;

  logic [7:0]         run_value_q, run_value_d;
  logic [RunLenW-1:0] run_length_q, run_length_d;
  logic               run_active_q, run_active_d;

  logic               accept;
  logic               close_a, close_b;
  logic [7:0]         new_value;
  logic [RunLenW-1:0] new_length;

  assign pix_rdy_o = !stat_i.full;
  assign accept    = pix_vld_i && pix_rdy_o;

  // Classify the pixel: does it close the open run, and does the new run close
  always_comb begin
    close_a = run_active_q && (pixel_i != run_value_q);
    if (run_active_q && !close_a) begin
      new_value  = run_value_q;
      new_length = run_length_q + RunLenW'(1);
    end else begin
      new_value  = pixel_i;
      new_length = RunLenW'(1);
    end
    close_b = row_end_i || (new_length >= RunLenW'(MaxRun));
  end

  // Command to the queue
  always_comb begin
    cmd_o.a_vld    = close_a;
    cmd_o.a.value  = run_value_q;
    cmd_o.a.length = run_length_q;
    cmd_o.b_vld    = close_b;
    cmd_o.b.value  = new_value;
    cmd_o.b.length = new_length;
  end
  assign push_o = accept && (close_a || close_b);

  // Run state update
  always_comb begin
    run_value_d  = run_value_q;
    run_length_d = run_length_q;
    run_active_d = run_active_q;
    if (accept) begin
      run_value_d  = new_value;
      run_length_d = close_b ? '0 : new_length;
      run_active_d = !close_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q  <= '0;
      run_length_q <= '0;
      run_active_q <= 1'b0;
    end else begin
      run_value_q  <= run_value_d;
      run_length_q <= run_length_d;
      run_active_q <= run_active_d;
    end
  end

  // An open run is never empty and is flushed before it reaches the limit
  a_open_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_active_q |-> (run_length_q != '0) && (run_length_q < RunLenW'(MaxRun)))
    else $error("open run length out of range");

  // No open run means zero length
  a_idle_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_active_q |-> (run_length_q == '0))
    else $error("length left over without an open run");

  // A row end always leaves no open run
  a_row_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && row_end_i) |=> !run_active_q)
    else $error("run survived a row end");

endmodule

// ----- design/prle_fifo.sv -----
// Short command queue between the front and back ends of the PCX run-length
// encoder. Depends on prle_pkg.
module prle_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  prle_pkg::cmd_t    data_i,
  input  logic              pop_i,
  output prle_pkg::cmd_t    head_o,
  output prle_pkg::fifo_stat_t stat_o
);
  import prle_pkg::*;

  cmd_t                entry_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoPtrW:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign stat_o.full  = (count_q == (FifoPtrW + 1)'(FifoDepth));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = entry_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + FifoPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + FifoPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (FifoPtrW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (FifoPtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/prle_back.sv -----
// Back end of the PCX run-length encoder: expands each queued command into
// its count and value bytes, one word per cycle while the receiver is ready,
// into an output register. Depends on prle_pkg.
module prle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prle_pkg::cmd_t    head_i,
  input  prle_pkg::fifo_stat_t stat_i,
  output logic              pop_o,
  output logic              out_vld_o,
  input  logic              out_rdy_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);
  import prle_pkg::*;

  logic [7:0] seq [4];
  logic [2:0] n_bytes;
  logic [1:0] idx_q, idx_d;
  logic       load, last_byte;
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  // Byte sequence of the head command
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      seq[i] = '0;
    end
    n_bytes = '0;
    if (head_i.a_vld) begin
      if (needs_count(head_i.a)) begin
        seq[n_bytes[1:0]] = count_byte(head_i.a);
        n_bytes = n_bytes + 3'd1;
      end
      seq[n_bytes[1:0]] = head_i.a.value;
      n_bytes = n_bytes + 3'd1;
    end
    if (head_i.b_vld) begin
      if (needs_count(head_i.b)) begin
        seq[n_bytes[1:0]] = count_byte(head_i.b);
        n_bytes = n_bytes + 3'd1;
      end
      seq[n_bytes[1:0]] = head_i.b.value;
      n_bytes = n_bytes + 3'd1;
    end
  end

  // Load the output register whenever the queue holds a command and the register is free or being drained
  assign load      = !stat_i.empty && (!out_vld_q || out_rdy_i);
  assign last_byte = ({1'b0, idx_q} == (n_bytes - 3'd1));
  assign pop_o     = load && last_byte;

  always_comb begin
    idx_d     = idx_q;
    out_vld_d = out_vld_q;
    if (load) begin
      idx_d     = last_byte ? '0 : idx_q + 2'd1;
      out_vld_d = 1'b1;
    end else if (out_rdy_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= seq[idx_q];
      out_last_q <= last_byte;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

  // Only commands that close a run are ever queued
  a_cmd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_i.empty |-> (head_i.a_vld || head_i.b_vld))
    else $error("queued command carries no run");

  // Byte index stays within the head command
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_i.empty |-> ({1'b0, idx_q} < n_bytes))
    else $error("byte index past end of command");

  // A partly sent command keeps the queue non-empty
  a_idx_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> !stat_i.empty)
    else $error("partial command lost from queue");

endmodule
